// ===== sv/mcrt_pkg.sv =====
// Shared constants, types and command struct for the motor channel run timer.
`default_nettype none

package mcrt_pkg;

    // Channel count and counter width
    localparam int CHANNELS   = 16;
    localparam int COUNT_BITS = 16;
    localparam int CHAN_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field widths fixed by the interface
    localparam int LIMIT_BITS   = 16;
    localparam int PATTERN_BITS = 16;
    localparam int DRIVE_BITS   = 16;
    localparam int CMP_BITS     = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

    // Configuration register indexes
    localparam int CFG_ADDR_BITS = 1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_UP_LIMIT   = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DOWN_LIMIT = 1'b1;

    // Reset value of both run limits
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd600;

    // Item kinds carried in tuser
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_PATTERN = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic                 load_item;  // capture the accepted item
        logic                 visit;      // update the channel at chan
        logic [CHAN_BITS-1:0] chan;       // channel being visited
        logic                 load_out;   // copy drive words to output register
    } mcrt_cmd_t;

endpackage

`default_nettype wire

// ===== sv/mcrt_ctrl.sv =====
// Controller: item handshake, channel sweep sequencing and output valid.
`default_nettype none

module mcrt_ctrl
    import mcrt_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    output mcrt_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    localparam logic [CHAN_BITS-1:0] LAST_CHAN = CHAN_BITS'(CHANNELS - 1);

    state_t               state_reg, state_next;
    logic [CHAN_BITS-1:0] chan_reg, chan_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 out_free;

    // Output register can take a new result when empty or being drained
    assign out_free = !m_valid_reg || m_tready;

    // Next state
    always_comb begin
        state_next    = state_reg;
        chan_next     = chan_reg;
        m_valid_next  = m_valid_reg;
        cmd.load_item = 1'b0;
        cmd.visit     = 1'b0;
        cmd.chan      = chan_reg;
        cmd.load_out  = 1'b0;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    chan_next     = '0;
                    state_next    = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                cmd.visit = 1'b1;
                if (chan_reg == LAST_CHAN) begin
                    state_next = ST_FINISH;
                end else begin
                    chan_next = chan_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            chan_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            chan_reg    <= chan_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

// ===== sv/mcrt_datapath.sv =====
// Datapath: limits, per-channel level, mode and run counter, output register.
`default_nettype none

module mcrt_datapath
    import mcrt_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire mcrt_cmd_t                cmd,
    input  wire logic                     item_cmd,
    input  wire logic [PATTERN_BITS-1:0]  item_pattern,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [LIMIT_BITS-1:0]    cfg_wdata,
    output logic [DRIVE_BITS-1:0]         in1_drive,
    output logic [DRIVE_BITS-1:0]         in2_drive
);

    logic [LIMIT_BITS-1:0] up_limit_reg, down_limit_reg;
    logic                  cmd_reg;
    logic [CHANNELS-1:0]   pattern_reg;
    logic [CHANNELS-1:0]   level_reg, level_next;
    logic [CHANNELS-1:0]   up_reg, up_next;
    logic [CHANNELS-1:0]   down_reg, down_next;
    logic [COUNT_BITS-1:0] count_reg [CHANNELS];
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] count_cur, count_inc;
    logic [LIMIT_BITS-1:0] limit_sel;
    logic                  running, want;
    logic [DRIVE_BITS-1:0] in1_wide, in2_wide;
    logic [DRIVE_BITS-1:0] in1_reg, in2_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_limit_reg   <= LIMIT_RESET;
            down_limit_reg <= LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_UP_LIMIT:   up_limit_reg   <= cfg_wdata;
                REG_DOWN_LIMIT: down_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Item capture
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            cmd_reg     <= item_cmd;
            pattern_reg <= item_pattern[CHANNELS-1:0];
        end
    end

    // One channel update per cycle
    assign running   = up_reg[cmd.chan] || down_reg[cmd.chan];
    assign want      = pattern_reg[cmd.chan];
    assign count_cur = count_reg[cmd.chan];
    assign count_inc = (count_cur == '1) ? count_cur : count_cur + COUNT_BITS'(1);
    assign limit_sel = up_reg[cmd.chan] ? up_limit_reg : down_limit_reg;

    always_comb begin
        level_next = level_reg;
        up_next    = up_reg;
        down_next  = down_reg;
        count_next = count_cur;
        if (cmd_reg == CMD_PATTERN) begin
            // stopped channel with a changed level starts moving
            if (!running && (level_reg[cmd.chan] != want)) begin
                up_next[cmd.chan]    = !want;
                down_next[cmd.chan]  = want;
                level_next[cmd.chan] = want;
            end
        end else if (running) begin
            // advance and stop past the limit for this direction
            if (CMP_BITS'(count_inc) > CMP_BITS'(limit_sel)) begin
                up_next[cmd.chan]   = 1'b0;
                down_next[cmd.chan] = 1'b0;
                count_next          = '0;
            end else begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
            up_reg    <= '0;
            down_reg  <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                count_reg[i] <= '0;
            end
        end else if (cmd.visit) begin
            level_reg           <= level_next;
            up_reg              <= up_next;
            down_reg            <= down_next;
            count_reg[cmd.chan] <= count_next;
        end
    end

    // Drive words, unused channels read zero
    always_comb begin
        in1_wide                 = '0;
        in2_wide                 = '0;
        in1_wide[CHANNELS-1:0]   = up_reg;
        in2_wide[CHANNELS-1:0]   = down_reg;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            in1_reg <= in1_wide;
            in2_reg <= in2_wide;
        end
    end

    assign in1_drive = in1_reg;
    assign in2_drive = in2_reg;

endmodule

`default_nettype wire

// ===== sv/motor_channel_run_timer.sv =====
// Top level: sixteen-channel H-bridge run timer with stream ports.
// Each item is accepted while idle, then all sixteen channels are swept one by one, then the
// drive words are loaded once the output is free; m_tvalid rises after that load.
// s_tready is high only while idle; a finished result may wait in the output register.
// Reset (aresetn, synchronous, active low): all channels stopped, levels and counts zero,
// both limits 600, no result pending.
`default_nettype none

module motor_channel_run_timer
    import mcrt_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [15:0]              s_tdata,   // [15:0] pin_pattern
    input  wire logic                     s_tuser,   // [0] cmd
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [31:0]                   m_tdata,   // [15:0] in1_drive, [31:16] in2_drive
    input  wire logic                     cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [LIMIT_BITS-1:0]    cfg_wdata
);

    mcrt_cmd_t             cmd;
    logic [DRIVE_BITS-1:0] in1_drive, in2_drive;

    mcrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    mcrt_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .item_cmd     (s_tuser),
        .item_pattern (s_tdata),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in1_drive    (in1_drive),
        .in2_drive    (in2_drive)
    );

    assign m_tdata = {in2_drive, in1_drive};

endmodule

`default_nettype wire

// ===== sv/mcrt_checker.sv =====
// Port-level checker for the run timer, bound to the top level.
`default_nettype none

module mcrt_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // A held result keeps its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No channel drives both bridge inputs
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[15:0] & m_tdata[31:16]) == 16'd0))
        else $error("channel driven up and down at once");

    // Busy right after an item is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready stayed high after accept");

    // Reset leaves no result pending
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind motor_channel_run_timer mcrt_checker u_mcrt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
